@@ hw/rtl/rvs_pkg.sv @@
// ----------------------------------------------------------------------------
// Raw value scaler package
// Field widths, register indexes, element type codes, handshake structs
// between the controller and its serial units, and the power-of-ten table.
// ----------------------------------------------------------------------------
package rvs_pkg;

  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DT_W       = 3;
  localparam int unsigned DP_W       = 4;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned DIFF_W     = 33;

  localparam int unsigned MUL_STEPS = DIFF_W;
  localparam int unsigned DIV_STEPS = ACC_W;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMALS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SI_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SI_MAX    = 3'd5;

  // single precision: exponent that leaves the significand unshifted, and
  // the all-ones exponent
  localparam logic [7:0] EXP_UNITY = 8'd150;
  localparam logic [7:0] EXP_INF   = 8'd255;

  typedef enum logic [DT_W-1:0] {
    DT_U8     = 3'd0,
    DT_S8     = 3'd1,
    DT_U16    = 3'd2,
    DT_S16    = 3'd3,
    DT_S16_BE = 3'd4,
    DT_U32    = 3'd5,
    DT_S32    = 3'd6,
    DT_F32    = 3'd7
  } data_type_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  a;
    logic [DIFF_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  num;
    logic [DIFF_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] q;
  } div_rsp_t;

  function automatic logic [ACC_W-1:0] pow10(input logic [DP_W-1:0] dp);
    logic [ACC_W-1:0] r;
    case (dp)
      4'd0:    r = 64'd1;
      4'd1:    r = 64'd10;
      4'd2:    r = 64'd100;
      4'd3:    r = 64'd1000;
      4'd4:    r = 64'd10000;
      4'd5:    r = 64'd100000;
      4'd6:    r = 64'd1000000;
      4'd7:    r = 64'd10000000;
      4'd8:    r = 64'd100000000;
      4'd9:    r = 64'd1000000000;
      4'd10:   r = 64'd10000000000;
      4'd11:   r = 64'd100000000000;
      4'd12:   r = 64'd1000000000000;
      4'd13:   r = 64'd10000000000000;
      4'd14:   r = 64'd100000000000000;
      default: r = 64'd1000000000000000;
    endcase
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] sext32(input logic [VAL_W-1:0] x);
    return {{(ACC_W-VAL_W){x[VAL_W-1]}}, x};
  endfunction

endpackage

@@ hw/rtl/rvs_if.sv @@
// ----------------------------------------------------------------------------
// Raw value scaler channels
// Valid/ready channels for sample words, result words and register writes.
// ----------------------------------------------------------------------------
interface rvs_in_if;
  import rvs_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] byte_address;
  logic [BYTE_W-1:0] byte_data;
  logic [IDX_W-1:0]  value_index;

  modport source (output valid, mode, byte_address, byte_data, value_index, input ready);
  modport sink   (input valid, mode, byte_address, byte_data, value_index, output ready);
endinterface

interface rvs_out_if;
  import rvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             saturated;

  modport source (output valid, value, saturated, input ready);
  modport sink   (input valid, value, saturated, output ready);
endinterface

interface rvs_cfg_if;
  import rvs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/sensor_raw_value_scaler_top.sv @@
// ----------------------------------------------------------------------------
// Sensor raw value scaler
// Byte store for raw samples, element decode, float-to-fixed conversion and
// linear range mapping with 32-bit saturation.
// ----------------------------------------------------------------------------
// Works on one word at a time. A write word (mode 0) puts one byte into the
// sample store and returns a zero result through the S_OUT state. A read
// word (mode 1) fetches one, two or four bytes from the store's single read
// port (one byte a cycle), decodes the element by data_type and returns the
// result. A float element adds a serial multiply by 10^decimals and then
// steps for rounding, shifting and sign; linear mapping (raw_min != raw_max)
// adds another serial multiply and a bit-serial divide. Both multiplies
// share the one-bit-a-cycle multiplier. The result sits in an output register,
// so the next word is taken while a result still waits. Registers may be
// written only while the block is idle; the store reads as zero after reset.
// ----------------------------------------------------------------------------
module sensor_raw_value_scaler_top #(
  parameter int unsigned STORE_BYTES = 32,
  parameter int unsigned VALUE_SLOTS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rvs_cfg_if.sink   cfg_i,
  rvs_in_if.sink    in_i,
  rvs_out_if.source out_o
);
  import rvs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FETCH  = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_FMUL   = 4'd3;
  localparam logic [3:0] S_FRND   = 4'd4;
  localparam logic [3:0] S_FSHF   = 4'd5;
  localparam logic [3:0] S_MAP    = 4'd6;
  localparam logic [3:0] S_MMUL   = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  // Configuration registers
  data_type_e       data_type_q;
  logic [DP_W-1:0]  decimals_q;
  logic [VAL_W-1:0] raw_min_q, raw_max_q, si_min_q, si_max_q;

  // Controller state
  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [2:0]       fcnt_q, fcnt_d;
  logic [31:0]      word_q, word_d;
  logic [ACC_W-1:0] v_q, v_d;
  logic [7:0]       exp_q, exp_d;
  logic             neg_q, neg_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;
  logic             out_sat_q, out_sat_d;

  logic              in_acc;
  logic [2:0]        n_bytes;
  logic [1:0]        size_log;
  logic [ADDR_W-1:0] base_addr;
  store_req_t        store_req;
  logic [BYTE_W-1:0] rdata;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [ACC_W-1:0]  dec_v;
  logic [7:0]        f_exp;
  logic              f_norm;
  logic              map_en;
  logic [DIFF_W-1:0] si_span, raw_span;
  logic [7:0]        sh_r, sh_l;
  logic              right_shift;
  logic [ACC_W-1:0]  rnd_mask, rnd_v, shf_v;
  logic              fits;

  // value_index modulo VALUE_SLOTS by repeated subtraction on three bits
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] r;
    r = {1'b0, idx};
    for (int k = 0; k < 8; k++) begin
      if (r >= (IDX_W+1)'(VALUE_SLOTS)) begin
        r = r - (IDX_W+1)'(VALUE_SLOTS);
      end
    end
    return r[IDX_W-1:0];
  endfunction

  // Register writes; indexes past the list are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_type_q <= DT_U8;
      decimals_q  <= '0;
      raw_min_q   <= '0;
      raw_max_q   <= '0;
      si_min_q    <= '0;
      si_max_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DATA_TYPE: data_type_q <= data_type_e'(cfg_i.data[DT_W-1:0]);
        REG_DECIMALS:  decimals_q  <= cfg_i.data[DP_W-1:0];
        REG_RAW_MIN:   raw_min_q   <= cfg_i.data;
        REG_RAW_MAX:   raw_max_q   <= cfg_i.data;
        REG_SI_MIN:    si_min_q    <= cfg_i.data;
        REG_SI_MAX:    si_max_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Element size by type: one, two or four bytes
  always_comb begin
    case (data_type_q)
      DT_U8, DT_S8: begin
        n_bytes  = 3'd1;
        size_log = 2'd0;
      end
      DT_U16, DT_S16, DT_S16_BE: begin
        n_bytes  = 3'd2;
        size_log = 2'd1;
      end
      default: begin
        n_bytes  = 3'd4;
        size_log = 2'd2;
      end
    endcase
  end

  assign base_addr = {2'b00, slot_q} << size_log;

  // Write on acceptance; read one byte a cycle while fetching
  assign store_req.we    = in_acc && (in_i.mode == MODE_WRITE);
  assign store_req.waddr = in_i.byte_address;
  assign store_req.wdata = in_i.byte_data;
  assign store_req.re    = (state_q == S_FETCH) && (fcnt_q < n_bytes);
  assign store_req.raddr = base_addr | {3'b000, fcnt_q[1:0]};

  rvs_store #(
    .STORE_BYTES(STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rdata_o(rdata)
  );

  rvs_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  rvs_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Bytes arrive lowest first and shift in from the top, so the element
  // always ends up in the upper bits of the fetch word
  assign f_exp  = word_q[30:23];
  assign f_norm = (f_exp != 8'd0) && (f_exp != EXP_INF);

  always_comb begin
    case (data_type_q)
      DT_U8:     dec_v = {56'd0, word_q[31:24]};
      DT_S8:     dec_v = {{56{word_q[31]}}, word_q[31:24]};
      DT_U16:    dec_v = {48'd0, word_q[31:16]};
      DT_S16:    dec_v = {{48{word_q[31]}}, word_q[31:16]};
      DT_S16_BE: dec_v = {{48{word_q[23]}}, word_q[23:16], word_q[31:24]};
      DT_U32:    dec_v = {32'd0, word_q};
      DT_S32:    dec_v = sext32(word_q);
      default: begin
        // float: zero exponent gives zero, all-ones exponent gives a bound
        if (f_exp == EXP_INF) begin
          dec_v = word_q[31] ? sext32(32'h8000_0000) : 64'h0000_0000_7FFF_FFFF;
        end else begin
          dec_v = '0;
        end
      end
    endcase
  end

  // Float scaling: round by half the bits shifted out, then shift
  assign right_shift = exp_q < EXP_UNITY;
  assign sh_r        = EXP_UNITY - exp_q;
  assign sh_l        = exp_q - EXP_UNITY;
  assign rnd_mask    = ~({ACC_W{1'b1}} << sh_r[5:0]);
  assign rnd_v       = (|sh_r[7:6]) ? '0 : v_q + ((v_q & rnd_mask) >> 1);

  always_comb begin
    if (right_shift) begin
      shf_v = (|sh_r[7:6]) ? '0 : v_q >> sh_r[5:0];
    end else begin
      shf_v = (|sh_l[7:6]) ? '0 : v_q << sh_l[5:0];
    end
  end

  // Linear mapping operands; spans fit in 33 bits
  assign map_en   = (raw_min_q != raw_max_q);
  assign si_span  = {si_max_q[VAL_W-1], si_max_q} - {si_min_q[VAL_W-1], si_min_q};
  assign raw_span = {raw_max_q[VAL_W-1], raw_max_q} - {raw_min_q[VAL_W-1], raw_min_q};

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = v_q - sext32(raw_min_q);
    mul_req.b     = si_span;
    if (state_q == S_DECODE) begin
      mul_req.start = (data_type_q == DT_F32) && f_norm;
      mul_req.a     = pow10(decimals_q);
      mul_req.b     = {9'd0, 1'b1, word_q[22:0]};
    end else if (state_q == S_MAP) begin
      mul_req.start = map_en;
    end
  end

  assign div_req.start = (state_q == S_MMUL) && mul_rsp.done;
  assign div_req.num   = mul_rsp.p;
  assign div_req.den   = raw_span;

  // Clamp to 32-bit signed
  assign fits = (&v_q[ACC_W-1:VAL_W-1]) || ~(|v_q[ACC_W-1:VAL_W-1]);

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    fcnt_d      = fcnt_q;
    word_d      = word_q;
    v_d         = v_q;
    exp_d       = exp_q;
    neg_d       = neg_q;
    out_value_d = out_value_q;
    out_sat_d   = out_sat_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.mode == MODE_WRITE) begin
            v_d     = '0;
            state_d = S_OUT;
          end else begin
            slot_d  = slot_of(in_i.value_index);
            fcnt_d  = '0;
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // read issued last cycle lands now
        if (fcnt_q != 3'd0) begin
          word_d = {rdata, word_q[31:BYTE_W]};
        end
        fcnt_d = fcnt_q + 3'd1;
        if (fcnt_q == n_bytes) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        v_d   = dec_v;
        exp_d = f_exp;
        neg_d = word_q[31];
        if ((data_type_q == DT_F32) && f_norm) begin
          state_d = S_FMUL;
        end else begin
          state_d = S_MAP;
        end
      end
      S_FMUL: begin
        if (mul_rsp.done) begin
          v_d     = mul_rsp.p;
          state_d = S_FRND;
        end
      end
      S_FRND: begin
        if (right_shift) begin
          v_d = rnd_v;
        end
        state_d = S_FSHF;
      end
      S_FSHF: begin
        v_d     = neg_q ? '0 - shf_v : shf_v;
        state_d = S_MAP;
      end
      S_MAP: begin
        state_d = map_en ? S_MMUL : S_OUT;
      end
      S_MMUL: begin
        if (mul_rsp.done) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          v_d     = div_rsp.q + sext32(si_min_q);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_sat_d   = !fits;
          if (fits) begin
            out_value_d = v_q[VAL_W-1:0];
          end else begin
            out_value_d = v_q[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fcnt_q      <= fcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    word_q      <= word_d;
    v_q         <= v_d;
    exp_q       <= exp_d;
    neg_q       <= neg_d;
    out_value_q <= out_value_d;
    out_sat_q   <= out_sat_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value     = out_value_q;
  assign out_o.saturated = out_sat_q;

endmodule

@@ hw/rtl/rvs_store.sv @@
// ----------------------------------------------------------------------------
// Raw value scaler sample store
// Byte memory with one write and one registered read port; per-byte valid
// flags make unwritten bytes read as zero after reset.
// ----------------------------------------------------------------------------
module rvs_store #(
  parameter int unsigned STORE_BYTES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rvs_pkg::store_req_t        req_i,
  output logic [rvs_pkg::BYTE_W-1:0] rdata_o
);
  import rvs_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);

  logic [BYTE_W-1:0]      mem_q [STORE_BYTES];
  logic [STORE_BYTES-1:0] valid_q;
  logic [BYTE_W-1:0]      rd_q;
  logic                   rv_q;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;

  assign waddr = AW'(req_i.waddr);
  assign raddr = AW'(req_i.raddr);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rv_q <= valid_q[raddr];
      end
    end
  end

  assign rdata_o = rv_q ? rd_q : '0;

endmodule

@@ hw/rtl/rvs_mul.sv @@
// ----------------------------------------------------------------------------
// Raw value scaler serial multiplier
// Shift-and-add over a 33-bit two's complement multiplier, one bit a cycle;
// the product is kept modulo 2^64.
// ----------------------------------------------------------------------------
module rvs_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rvs_pkg::mul_req_t req_i,
  output rvs_pkg::mul_rsp_t rsp_o
);
  import rvs_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  a_q;
  logic [DIFF_W-1:0] b_q;
  logic [ACC_W-1:0]  addend;
  logic              last;

  assign addend = b_q[0] ? a_q : '0;
  assign last   = (cnt_q == 6'(MUL_STEPS - 1));
  // sign bit of the multiplier carries negative weight
  assign acc_d  = last ? acc_q - addend : acc_q + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
    end else if (busy_q) begin
      acc_q <= acc_d;
      a_q   <= {a_q[ACC_W-2:0], 1'b0};
      b_q   <= {1'b0, b_q[DIFF_W-1:1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

@@ hw/rtl/rvs_div.sv @@
// ----------------------------------------------------------------------------
// Raw value scaler serial divider
// Signed restoring division, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rvs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rvs_pkg::div_req_t req_i,
  output rvs_pkg::div_rsp_t rsp_o
);
  import rvs_pkg::*;

  logic              busy_q;
  logic              fix_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  logic [ACC_W-1:0]  quo_q;
  logic [DIFF_W-1:0] rem_q, rem_d;
  logic [DIFF_W-1:0] den_q;
  logic              neg_q;
  logic [DIFF_W:0]   shifted;
  logic [DIFF_W:0]   trial;
  logic              qbit;

  assign shifted = {rem_q, quo_q[ACC_W-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign qbit    = ~trial[DIFF_W];
  assign rem_d   = qbit ? trial[DIFF_W-1:0] : shifted[DIFF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        fix_q  <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end else if (fix_q) begin
        fix_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num[ACC_W-1] ? '0 - req_i.num : req_i.num;
      den_q <= req_i.den[DIFF_W-1] ? '0 - req_i.den : req_i.den;
      rem_q <= '0;
      neg_q <= req_i.num[ACC_W-1] ^ req_i.den[DIFF_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[ACC_W-2:0], qbit};
      rem_q <= rem_d;
    end else if (fix_q) begin
      quo_q <= neg_q ? '0 - quo_q : quo_q;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;

endmodule

@@ hw/rtl/rvs_checker.sv @@
// ----------------------------------------------------------------------------
// Raw value scaler port checker
// Watches the top-level channels for ordering and result consistency.
// ----------------------------------------------------------------------------
module rvs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rvs_pkg::VAL_W-1:0] out_value_i,
  input logic                      out_saturated_i
);

  // a clamped result is one of the two 32-bit bounds
  ap_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_saturated_i) |->
      (out_value_i == 32'h7FFF_FFFF || out_value_i == 32'h8000_0000))
    else $error("saturated result is not a 32-bit bound");

  // one word in flight: taking a word closes the input side
  ap_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted again while a word is in flight");

  // a fresh result only comes out of a busy block
  ap_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a word in flight");

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_value_i) && $stable(out_saturated_i)))
    else $error("stalled result changed");

endmodule

bind sensor_raw_value_scaler_top rvs_checker u_rvs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_i    (out_o.value),
  .out_saturated_i(out_o.saturated)
);
